### sv/four_level_page_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-level page table
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_ASSERT_SVH

// Same-cycle implication.
`define FLPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FLPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/flpt_pkg.sv
// ----------------------------------------------------------------------------
// flpt_pkg
// Beat types, request codes and walk states of the four-level page table.
// ----------------------------------------------------------------------------
`default_nettype none

package flpt_pkg;

  localparam int VA_BITS    = 48;
  localparam int ENTRY_BITS = 64;
  localparam int REQ_BITS   = 2;

  localparam logic [REQ_BITS-1:0] REQ_MAP    = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic [REQ_BITS-1:0]   req_type;
    logic [VA_BITS-1:0]    virt_addr;
    logic [ENTRY_BITS-1:0] phys_value;
  } flpt_in_t;

  typedef struct packed {
    logic [ENTRY_BITS-1:0] phys_result;
    logic                  status;
  } flpt_out_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

### sv/flpt_ram.sv
// ----------------------------------------------------------------------------
// flpt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module flpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/four_level_page_table.sv
// Lookup: a read and a check per level from the root down, then the result beat.
// Map: the same walk, writing the leaf directly; each table taken from the pool is zeroed.
// Clear: a sweep of the root table; unknown request: straight to the result beat.
// One request in flight; the single table memory port sets the pace of the walk.
// Reset: a root clearing pass over all 2^INDEX_BITS slots runs first, in_stall held high.
// A result beat waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
// four_level_page_table
// Radix page table walker over a fixed pool of tables kept in one memory.
// ----------------------------------------------------------------------------
`default_nettype none
`include "four_level_page_table_assert.svh"

module four_level_page_table
  import flpt_pkg::*;
#(
  parameter int TABLE_COUNT = 64,
  parameter int INDEX_BITS  = 9,
  parameter int LEVEL_COUNT = 4,
  parameter int PAGE_SHIFT  = 12
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire flpt_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output flpt_out_t      out_data
);

  // Table number width, memory address width, pool counter width, level width.
  localparam int TW    = $clog2(TABLE_COUNT);
  localparam int DEPTH = TABLE_COUNT * (1 << INDEX_BITS);
  localparam int AW    = $clog2(DEPTH);
  localparam int UW    = $clog2(TABLE_COUNT + 1);
  localparam int LW    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam logic [LW-1:0] LAST_LVL = LW'(LEVEL_COUNT - 1);

  // Control state.
  state_t                state_r, state_nxt;
  logic                  init_r;      // first root sweep after reset
  logic [UW-1:0]         used_r;      // tables taken from the pool
  logic [TW-1:0]         tbl_r;       // table being walked or swept
  logic [LW-1:0]         level_r;
  logic [INDEX_BITS-1:0] sw_idx_r;    // sweep slot
  logic                  out_valid_r;

  // Request and result payload.
  logic [REQ_BITS-1:0]   req_r;
  logic [VA_BITS-1:0]    va_r;
  logic [ENTRY_BITS-1:0] pv_r;
  logic [ENTRY_BITS-1:0] res_r;
  logic                  stat_r;
  flpt_out_t             out_data_r;

  // Memory port.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ENTRY_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ENTRY_BITS-1:0] ram_rdata;

  logic                  in_acc;
  logic                  out_free;
  logic                  entry_empty;
  logic                  pool_full;
  logic                  sweep_last;
  logic                  at_leaf;
  logic [ENTRY_BITS-1:0] va_ext;
  logic [INDEX_BITS-1:0] lvl_idx [LEVEL_COUNT];
  logic [AW-1:0]         cur_addr;

  // All table entries: one row of 2^INDEX_BITS slots per pool table.
  flpt_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Per-level index fields at fixed bit positions; the root takes the highest.
  // A field that starts past the top of the address reads as zero.
  assign va_ext = ENTRY_BITS'(va_r);

  for (genvar g = 0; g < LEVEL_COUNT; g++) begin : g_lvl
    localparam int SH = PAGE_SHIFT + INDEX_BITS * (LEVEL_COUNT - 1 - g);
    assign lvl_idx[g] = (SH >= ENTRY_BITS) ? '0 : INDEX_BITS'(va_ext >> SH);
  end

  assign cur_addr    = {tbl_r, lvl_idx[level_r]};
  assign at_leaf     = (level_r == LAST_LVL);
  assign in_acc      = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign sweep_last  = (sw_idx_r == '1);
  assign pool_full   = (used_r >= UW'(TABLE_COUNT));

  // A child link is a pool number from 1 to TABLE_COUNT-1; anything else counts as no child.
  assign entry_empty = (ram_rdata == '0) || (ram_rdata >= ENTRY_BITS'(TABLE_COUNT));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        if (sweep_last) begin
          if (init_r) begin
            state_nxt = S_IDLE;
          end else if (req_r == REQ_MAP) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.req_type) inside
            REQ_MAP, REQ_LOOKUP: state_nxt = S_READ;
            REQ_CLEAR:           state_nxt = S_SWEEP;
            default:             state_nxt = S_RESP;
          endcase
        end
      end
      S_READ: begin
        if (at_leaf && req_r == REQ_MAP) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (at_leaf) begin
          state_nxt = S_RESP;
        end else if (!entry_empty) begin
          state_nxt = S_READ;
        end else if (req_r != REQ_MAP || pool_full) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SWEEP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory port and input stall.
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = '0;
    ram_raddr = cur_addr;
    unique case (state_r)
      S_SWEEP: begin
        // Zero one slot of the swept table per cycle.
        ram_we    = 1'b1;
        ram_waddr = {tbl_r, sw_idx_r};
      end
      S_READ: begin
        // Map writes the leaf straight away; no read needed at the last level.
        if (at_leaf && req_r == REQ_MAP) begin
          ram_we    = 1'b1;
          ram_wdata = pv_r;
        end
      end
      S_CHECK: begin
        // Link the next free table into the empty slot just read.
        if (!at_leaf && entry_empty && req_r == REQ_MAP && !pool_full) begin
          ram_we    = 1'b1;
          ram_wdata = ENTRY_BITS'(used_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      init_r      <= 1'b1;
      used_r      <= UW'(1);
      tbl_r       <= '0;
      level_r     <= '0;
      sw_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_SWEEP: begin
          sw_idx_r <= sw_idx_r + INDEX_BITS'(1);
          if (sweep_last) begin
            init_r <= 1'b0;
            // Fresh child is zeroed; advance to walk it.
            if (!init_r && req_r == REQ_MAP) begin
              level_r <= level_r + LW'(1);
            end
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            tbl_r   <= '0;
            level_r <= '0;
            if (in_data.req_type == REQ_CLEAR) begin
              used_r <= UW'(1);
            end
          end
        end
        S_CHECK: begin
          if (!at_leaf) begin
            if (!entry_empty) begin
              tbl_r   <= ram_rdata[TW-1:0];
              level_r <= level_r + LW'(1);
            end else if (req_r == REQ_MAP && !pool_full) begin
              tbl_r  <= used_r[TW-1:0];
              used_r <= used_r + UW'(1);
            end
          end
        end
        default: begin
        end
      endcase

      // Output register: load a result beat when free, drop it once taken.
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_data.req_type;
      va_r   <= in_data.virt_addr;
      pv_r   <= in_data.phys_value;
      res_r  <= '0;
      stat_r <= 1'b0;
    end
    if (state_r == S_CHECK) begin
      if (at_leaf) begin
        res_r <= ram_rdata;
      end else if (entry_empty && req_r == REQ_MAP && pool_full) begin
        stat_r <= 1'b1;
      end
    end
    if (state_r == S_RESP && out_free) begin
      out_data_r.phys_result <= res_r;
      out_data_r.status      <= stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FLPT_ASSERT_IMP(a_pool_bound, 1'b1, used_r <= UW'(TABLE_COUNT), "pool count past table count")
  `FLPT_ASSERT_NXT(a_accept_busy, in_acc, state_r != S_IDLE, "accepted beat left block idle")
  `FLPT_ASSERT_IMP(a_lookup_no_write, (state_r == S_READ || state_r == S_CHECK) && req_r == REQ_LOOKUP, !ram_we, "lookup wrote table memory")
  `FLPT_ASSERT_NXT(a_link_sweep, state_r == S_CHECK && ram_we, state_r == S_SWEEP && sw_idx_r == '0, "new table linked without zeroing")

endmodule

`default_nettype wire

### dv/four_level_page_table_test.sv
// ----------------------------------------------------------------------------
// four_level_page_table_test
// Self-checking bench for the page table walker: a short table of directed
// beats, then about a thousand random map, lookup, clear and unknown requests
// aimed at a few hot address paths, checked by a local walk model or typed answer.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_test;
  import flpt_pkg::*;

  // Geometry of the block at its default parameters.
  localparam int SLOTS       = 512;
  localparam int POOL_TABLES = 64;
  localparam int LEVELS      = 4;
  localparam int IDX_BITS    = 9;
  localparam int PAGE_SHIFT  = 12;

  // The package names three request codes; the fourth leaves the tables untouched and gets an empty result beat.
  localparam logic [REQ_BITS-1:0] REQ_UNKNOWN = 2'd3;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOT_PATHS    = 8;
  localparam int DRAIN_CYCLES = 20;
  // Worst gap between two beats: a map taking three tables from the pool,
  // or the root clearing pass after reset, plus random stalls on both sides.
  localparam int STALL_LIMIT  = 8000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  flpt_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  flpt_out_t out_data;

  four_level_page_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // --------------------------------------------------------------------------
  // Walk model: sparse copy of the table memory plus the pool counter.
  // Entries never written read as zero.
  // --------------------------------------------------------------------------
  logic [63:0] pt_entries [int];
  int unsigned pt_tables_used;

  function automatic logic [IDX_BITS-1:0] va_index(logic [VA_BITS-1:0] va, int lvl);
    int sh;
    sh = PAGE_SHIFT + IDX_BITS * (LEVELS - 1 - lvl);
    va_index = IDX_BITS'(va >> sh);
  endfunction

  function automatic int entry_at(int unsigned tbl, logic [IDX_BITS-1:0] idx);
    entry_at = int'(tbl * SLOTS + idx);
  endfunction

  function automatic logic [63:0] pt_read(int addr);
    pt_read = pt_entries.exists(addr) ? pt_entries[addr] : 64'd0;
  endfunction

  // Apply one request to the model and return the result beat it causes.
  function automatic flpt_out_t translate_step(flpt_in_t b);
    flpt_out_t   r;
    logic [63:0] child;
    int unsigned tbl;
    int          addr;
    bit          walk_ok;
    r       = '0;
    tbl     = 0;
    walk_ok = 1'b1;
    case (b.req_type)
      REQ_MAP: begin
        for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
          addr  = entry_at(tbl, va_index(b.virt_addr, lvl));
          child = pt_read(addr);
          if (child == 0 || child >= POOL_TABLES) begin
            // Empty pool: stop here, tables already linked stay linked.
            if (pt_tables_used >= POOL_TABLES) begin
              walk_ok = 1'b0;
              break;
            end
            // A table coming back from the pool after a clear starts empty.
            for (int i = 0; i < SLOTS; i++)
              pt_entries[int'(pt_tables_used * SLOTS + i)] = 64'd0;
            pt_entries[addr] = 64'(pt_tables_used);
            child            = 64'(pt_tables_used);
            pt_tables_used++;
          end
          tbl = 32'(child);
        end
        if (walk_ok)
          pt_entries[entry_at(tbl, va_index(b.virt_addr, LEVELS - 1))] = b.phys_value;
        r.status = !walk_ok;
      end
      REQ_LOOKUP: begin
        for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
          child = pt_read(entry_at(tbl, va_index(b.virt_addr, lvl)));
          if (child == 0 || child >= POOL_TABLES) begin
            walk_ok = 1'b0;
            break;
          end
          tbl = 32'(child);
        end
        if (walk_ok)
          r.phys_result = pt_read(entry_at(tbl, va_index(b.virt_addr, LEVELS - 1)));
      end
      REQ_CLEAR: begin
        // Only the root is wiped; the rest is wiped lazily on reuse.
        for (int i = 0; i < SLOTS; i++)
          pt_entries[i] = 64'd0;
        pt_tables_used = 1;
      end
      default: ;
    endcase
    translate_step = r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed beats. A typed row carries its own answer; the others are
  // checked against the walk model.
  // --------------------------------------------------------------------------
  typedef struct {
    logic [REQ_BITS-1:0]   req;
    logic [VA_BITS-1:0]    va;
    logic [ENTRY_BITS-1:0] pv;
    bit                    typed;
    logic [ENTRY_BITS-1:0] want_phys;
    logic                  want_status;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty table right after reset
    '{REQ_LOOKUP,  48'h0000_0000_0000, 64'h0,                   1, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'hFFFF_FFFF_FFFF, ONES,                    1, 64'h0, 1'b0},
    // lowest address gets the widest value; page offset bits do not matter
    '{REQ_MAP,     48'h0000_0000_0000, ONES,                    1, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'h0000_0000_0FFF, 64'h0,                   1, ONES,  1'b0},
    // mapping zero looks the same as no mapping
    '{REQ_MAP,     48'hFFFF_FFFF_FFFF, 64'h0,                   1, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'hFFFF_FFFF_F000, ONES,                    1, 64'h0, 1'b0},
    // neighbor leaf in the same last-level table
    '{REQ_MAP,     48'hFFFF_FFFF_E000, 64'h8000_0000_0000_0001, 0, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'hFFFF_FFFF_E123, 64'h0,                   0, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'hFFFF_FFE0_0000, 64'h0,                   0, 64'h0, 1'b0},
    // root entry never filled
    '{REQ_LOOKUP,  48'h8000_0000_0000, 64'h0,                   1, 64'h0, 1'b0},
    // unknown request does nothing
    '{REQ_UNKNOWN, 48'hFFFF_FFFF_FFFF, ONES,                    1, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'h0000_0000_0000, 64'h0,                   1, ONES,  1'b0},
    // alternating patterns, then an overwrite of a live leaf
    '{REQ_MAP,     48'h5555_5555_5555, 64'hAAAA_AAAA_5555_5555, 0, 64'h0, 1'b0},
    '{REQ_MAP,     48'hAAAA_AAAA_AAAA, 64'h5555_5555_AAAA_AAAA, 0, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'h5555_5555_5555, 64'h0,                   0, 64'h0, 1'b0},
    '{REQ_MAP,     48'h5555_5555_5555, 64'h0123_4567_89AB_CDEF, 0, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'h5555_5555_5000, 64'h0,                   0, 64'h0, 1'b0},
    // clear leaves a lone empty root
    '{REQ_CLEAR,   48'hFFFF_FFFF_FFFF, ONES,                    1, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'h0000_0000_0000, 64'h0,                   1, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'hAAAA_AAAA_AAAA, 64'h0,                   1, 64'h0, 1'b0},
    // reused pool tables must come back zeroed: the stale slot 0 of
    // the old second-level table must not show through
    '{REQ_MAP,     48'hAAAA_AAAA_AAAA, 64'h1,                   0, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'hAA80_2AAA_AAAA, 64'h0,                   1, 64'h0, 1'b0},
    '{REQ_LOOKUP,  48'hAAAA_AAAA_A000, 64'h0,                   0, 64'h0, 1'b0}
  };

  // --------------------------------------------------------------------------
  // Random stimulus: most addresses branch off a few hot paths so that maps
  // share tables and lookups hit; fresh addresses drain the pool until the
  // next clear.
  // --------------------------------------------------------------------------
  logic [VA_BITS-1:0] hot_va [HOT_PATHS];

  function automatic logic [VA_BITS-1:0] near_va(logic [VA_BITS-1:0] base);
    logic [VA_BITS-1:0] rnd;
    rnd = VA_BITS'({$urandom, $urandom});
    case ($urandom_range(9))
      0, 1, 2, 3: near_va = {base[47:12], rnd[11:0]};  // same page
      4, 5:       near_va = {base[47:21], rnd[20:0]};  // same last-level table
      6:          near_va = {base[47:30], rnd[29:0]};  // same third-level table
      7:          near_va = {base[47:39], rnd[38:0]};  // same root entry
      default:    near_va = rnd;                       // anywhere
    endcase
  endfunction

  function automatic flpt_in_t random_beat();
    flpt_in_t    b;
    int unsigned pick;
    pick         = $urandom_range(999);
    b.virt_addr  = near_va(hot_va[$urandom_range(HOT_PATHS - 1)]);
    b.phys_value = ($urandom_range(19) == 0) ? 64'd0 : {$urandom, $urandom};
    if (pick < 10)
      b.req_type = REQ_CLEAR;
    else if (pick < 40)
      b.req_type = REQ_UNKNOWN;
    else if (pick < 500)
      b.req_type = REQ_MAP;
    else
      b.req_type = REQ_LOOKUP;
    random_beat = b;
  endfunction

  // --------------------------------------------------------------------------
  // Flow control on both sides, switched by progress through the stimulus.
  // --------------------------------------------------------------------------
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned beats_sent;

  flpt_out_t expected_q [$];
  int        errors;

  // Drive one request beat, hold it until accepted, then log what it owes.
  task automatic send_beat(input flpt_in_t b, input bit typed, input flpt_out_t typed_res);
    flpt_out_t predicted;
    case (beats_sent * 3 / (DIR_ROWS + RANDOM_ITEMS))
      0: begin
        send_idle_pct  = 12;
        recv_stall_pct = 70;
      end
      1: begin
        send_idle_pct  = 70;
        recv_stall_pct = 12;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    predicted = translate_step(b);
    expected_q.push_back(typed ? typed_res : predicted);
    beats_sent++;
  endtask

  // Receiver stalls are redrawn every cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result checker: compare every accepted result beat with the oldest
  // outstanding expectation.
  // --------------------------------------------------------------------------
  flpt_out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing outstanding: phys_result %h status %b",
               out_data.phys_result, out_data.status);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.phys_result !== want.phys_result) begin
          $error("phys_result: expected %h, got %h", want.phys_result, out_data.phys_result);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %b, got %b", want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  // Watchdog: give up when no beat moves on either side for too long.
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    flpt_in_t  b;
    flpt_out_t typed_res;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    beats_sent     = 0;
    errors         = 0;
    quiet_cycles   = 0;
    pt_tables_used = 1;
    for (int i = 0; i < HOT_PATHS; i++)
      hot_va[i] = VA_BITS'({$urandom, $urandom});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows; the block holds in_stall through its root sweep.
    for (int i = 0; i < DIR_ROWS; i++) begin
      b.req_type            = dir_rows[i].req;
      b.virt_addr           = dir_rows[i].va;
      b.phys_value          = dir_rows[i].pv;
      typed_res.phys_result = dir_rows[i].want_phys;
      typed_res.status      = dir_rows[i].want_status;
      send_beat(b, dir_rows[i].typed, typed_res);
    end

    // Random rows; pick new hot paths after each clear.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      b = random_beat();
      send_beat(b, 1'b0, '0);
      if (b.req_type == REQ_CLEAR) begin
        for (int i = 0; i < HOT_PATHS; i++)
          hot_va[i] = VA_BITS'({$urandom, $urandom});
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block settle.
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
